// ----- rtl/next_hop_routing_table_macros.svh -----
// Assertion macros for the next-hop routing table.
`ifndef NEXT_HOP_ROUTING_TABLE_MACROS_SVH
`define NEXT_HOP_ROUTING_TABLE_MACROS_SVH

// Checked only while out of reset.
`define NHRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define NHRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/nhrt_pkg.sv -----
package nhrt_pkg;

    localparam int DEST_W      = 8;
    localparam int HOP_W       = 8;
    localparam int SLOTS_DEF   = 16;
    localparam int WAYS_DEF    = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_SET    = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISS     = 2'd3
    } t_status;

    // command word as queued between front and back
    typedef struct packed {
        t_op               op;
        logic [DEST_W-1:0] dest;
        logic [HOP_W-1:0]  hop;
    } t_cmd;

    // one way of a slot row
    typedef struct packed {
        logic              valid;
        logic [DEST_W-1:0] dest;
        logic [HOP_W-1:0]  hop;
    } t_way;

endpackage

// ----- rtl/nhrt_front.sv -----
module nhrt_front #(
    parameter int SLOTS = nhrt_pkg::SLOTS_DEF
) (
    input  logic                       i_start,
    input  logic                       i_opcode,
    input  logic [nhrt_pkg::DEST_W-1:0] i_dest_node,
    input  logic [nhrt_pkg::HOP_W-1:0]  i_next_hop_in,
    input  logic                       i_q_full,
    input  logic                       i_clearing,
    output logic                       o_busy,
    output logic                       o_push,
    output nhrt_pkg::t_cmd             o_push_cmd,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] o_push_slot
);

    localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_VALS = 1 << nhrt_pkg::DEST_W;

    // dest modulo SLOTS, as a constant table
    logic [SW-1:0] slot_lut [KEY_VALS];

    for (genvar g = 0; g < KEY_VALS; g++) begin : g_lut
        assign slot_lut[g] = SW'(g % SLOTS);
    end

    assign o_busy           = i_q_full | i_clearing;
    assign o_push           = i_start & ~o_busy;
    assign o_push_cmd.op    = nhrt_pkg::t_op'(i_opcode);
    assign o_push_cmd.dest  = i_dest_node;
    assign o_push_cmd.hop   = i_next_hop_in;
    assign o_push_slot      = slot_lut[i_dest_node];

endmodule

// ----- rtl/nhrt_fifo.sv -----
module nhrt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = nhrt_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/nhrt_back.sv -----
module nhrt_back #(
    parameter int SLOTS = nhrt_pkg::SLOTS_DEF,
    parameter int WAYS  = nhrt_pkg::WAYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  nhrt_pkg::t_cmd             i_cmd,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] i_slot,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic                       o_hit,
    output logic [nhrt_pkg::HOP_W-1:0] o_next_hop_out
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    // one row per slot, all ways side by side
    nhrt_pkg::t_way [WAYS-1:0] mem [SLOTS];

    t_state                    r_state;
    logic [SW-1:0]             r_clr_cnt;
    logic [SW-1:0]             r_slot;
    nhrt_pkg::t_cmd            r_cmd;
    nhrt_pkg::t_way [WAYS-1:0] r_row;
    logic                      r_valid;
    nhrt_pkg::t_status         r_status;
    logic                      r_hit;
    logic [nhrt_pkg::HOP_W-1:0] r_hop;

    logic                      m_found;
    logic [WW-1:0]             m_idx;
    logic                      f_found;
    logic [WW-1:0]             f_idx;
    nhrt_pkg::t_way [WAYS-1:0] new_row;
    logic                      wr_en;
    nhrt_pkg::t_status         res_status;
    logic                      res_hit;
    logic [nhrt_pkg::HOP_W-1:0] res_hop;

    assign o_pop          = (r_state == S_IDLE) && !i_empty;
    assign o_clearing     = (r_state == S_CLEAR);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_hit          = r_hit;
    assign o_next_hop_out = r_hop;

    // lowest matching way and lowest free way of the row
    always_comb begin
        m_found    = 1'b0;
        m_idx      = '0;
        f_found    = 1'b0;
        f_idx      = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_row[w].valid && (r_row[w].dest == r_cmd.dest)) begin
                m_found = 1'b1;
                m_idx   = WW'(w);
            end
            if (!r_row[w].valid) begin
                f_found = 1'b1;
                f_idx   = WW'(w);
            end
        end

        new_row    = r_row;
        wr_en      = 1'b0;
        res_status = nhrt_pkg::ST_MISS;
        res_hit    = 1'b0;
        res_hop    = '0;
        if (r_cmd.op == nhrt_pkg::OP_SET) begin
            if (m_found) begin
                new_row[m_idx].hop = r_cmd.hop;
                wr_en              = 1'b1;
                res_status         = nhrt_pkg::ST_UPDATED;
                res_hit            = 1'b1;
            end else if (f_found) begin
                new_row[f_idx].valid = 1'b1;
                new_row[f_idx].dest  = r_cmd.dest;
                new_row[f_idx].hop   = r_cmd.hop;
                wr_en                = 1'b1;
                res_status           = nhrt_pkg::ST_INSERTED;
            end
        end else if (m_found) begin
            res_status = nhrt_pkg::ST_FOUND;
            res_hit    = 1'b1;
            res_hop    = r_row[m_idx].hop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr_cnt] <= '0;
        end else if ((r_state == S_EVAL) && wr_en) begin
            mem[r_slot] <= new_row;
        end
        if (o_pop) begin
            r_row <= mem[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_cnt == SW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_cnt <= r_clr_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_slot  <= i_slot;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_valid  <= 1'b1;
                    r_status <= res_status;
                    r_hit    <= res_hit;
                    r_hop    <= res_hop;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/next_hop_routing_table.sv -----
// Next-hop routing table: maps an 8-bit destination node to an 8-bit next hop.
// The slot is dest_node modulo SLOTS; each slot holds WAYS ways. A set word
// (opcode 0) overwrites the next hop of a matching way, else fills the lowest
// free way, else is dropped with status 3 (table full). A lookup word
// (opcode 1) returns status 2 and the next hop on a hit, status 3 and zero
// otherwise. A word is taken at a clock edge where start is high and busy is
// low. Exactly one result word follows each input word, shown for one cycle
// with o_valid high; the receiver cannot stall, so it must take it then.
// The back end takes one word at a time: it reads the word's slot row from the
// table memory, then compares and writes it back, and pops no new word before
// that. With the queue empty and the back end idle, an accepted word passes
// through the queue, the row read and the evaluation before o_valid rises. A
// 2-word queue sits between the front and back end; busy rises when it is full.
// After reset a clearing pass over all SLOTS rows zeroes the valid marks, and
// busy stays high throughout.
module next_hop_routing_table #(
    parameter int SLOTS = nhrt_pkg::SLOTS_DEF,
    parameter int WAYS  = nhrt_pkg::WAYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic [nhrt_pkg::DEST_W-1:0] i_dest_node,
    input  logic [nhrt_pkg::HOP_W-1:0]  i_next_hop_in,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic                        o_hit,
    output logic [nhrt_pkg::HOP_W-1:0]  o_next_hop_out
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW    = SW + $bits(nhrt_pkg::t_cmd);

    // front end to queue
    logic            push;
    nhrt_pkg::t_cmd  push_cmd;
    logic [SW-1:0]   push_slot;
    // queue to back end
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic [QW-1:0]   q_data;
    nhrt_pkg::t_cmd  q_cmd;
    logic [SW-1:0]   q_slot;
    logic            clearing;

    assign q_cmd  = nhrt_pkg::t_cmd'(q_data[QW-SW-1:0]);
    assign q_slot = q_data[QW-1:QW-SW];

    // accept and classify: handshake plus slot index
    nhrt_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_dest_node   (i_dest_node),
        .i_next_hop_in (i_next_hop_in),
        .i_q_full      (q_full),
        .i_clearing    (clearing),
        .o_busy        (busy),
        .o_push        (push),
        .o_push_cmd    (push_cmd),
        .o_push_slot   (push_slot)
    );

    // decoupling queue
    nhrt_fifo #(
        .W     (QW),
        .DEPTH (nhrt_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_slot, push_cmd}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // table engine: read row, resolve, write back, report
    nhrt_back #(
        .SLOTS (SLOTS),
        .WAYS  (WAYS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_cmd          (q_cmd),
        .i_slot         (q_slot),
        .o_pop          (q_pop),
        .o_clearing     (clearing),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_hit          (o_hit),
        .o_next_hop_out (o_next_hop_out)
    );

endmodule

// ----- rtl/nhrt_checker.sv -----
`include "next_hop_routing_table_macros.svh"

module nhrt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_opcode,
    input logic [nhrt_pkg::DEST_W-1:0] i_dest_node,
    input logic [nhrt_pkg::HOP_W-1:0]  i_next_hop_in,
    input logic                        o_valid,
    input logic [1:0]                  o_status,
    input logic                        o_hit,
    input logic [nhrt_pkg::HOP_W-1:0]  o_next_hop_out
);

    // clearing pass starts right out of reset
    `NHRT_ASSERT_ALWAYS(a_busy_after_reset, !i_rst_n |=> busy, "busy low after reset")

    // back end returns to idle after each result, so results never come back to back
    `NHRT_ASSERT(a_no_b2b_result, o_valid |=> !o_valid, "results in consecutive cycles")

    // hit goes with updated or found, and only those
    `NHRT_ASSERT(a_hit_status, o_valid |-> (o_hit == ((o_status == nhrt_pkg::ST_UPDATED) || (o_status == nhrt_pkg::ST_FOUND))), "hit disagrees with status")

    // next hop is zero unless a lookup hit
    `NHRT_ASSERT(a_hop_zero, (o_valid && (o_status != nhrt_pkg::ST_FOUND)) |-> (o_next_hop_out == '0), "nonzero next hop without lookup hit")

endmodule

bind next_hop_routing_table nhrt_checker u_nhrt_checker (.*);

// ----- tb/next_hop_routing_table_checker.sv -----
`timescale 1ns / 1ps

module next_hop_routing_table_checker
    import nhrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_opcode,
    input  logic [DEST_W-1:0] i_dest_node,
    input  logic [HOP_W-1:0]  i_next_hop_in,
    input  logic              i_valid,
    input  logic [1:0]        i_status,
    input  logic              i_hit,
    input  logic [HOP_W-1:0]  i_next_hop_out,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int N_WAYS = SLOTS_DEF * WAYS_DEF;

    typedef struct {
        t_status          status;
        logic             hit;
        logic [HOP_W-1:0] hop;
    } route_reply_t;

    logic             route_valid [N_WAYS];
    logic [DEST_W-1:0] route_dest [N_WAYS];
    logic [HOP_W-1:0] route_hop   [N_WAYS];

    route_reply_t awaited_replies[$];
    route_reply_t want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Own copy of the table: search the slot, then update/insert/report.
    function automatic route_reply_t route_word(t_op op, logic [DEST_W-1:0] dest,
                                                logic [HOP_W-1:0] hop);
        int base;
        int hit_way;
        int spare_way;
        route_reply_t r;
        base      = (int'(dest) % SLOTS_DEF) * WAYS_DEF;
        hit_way   = -1;
        spare_way = -1;
        for (int w = 0; w < WAYS_DEF; w++) begin
            if (route_valid[base + w]) begin
                if (hit_way < 0 && route_dest[base + w] == dest)
                    hit_way = base + w;
            end else if (spare_way < 0) begin
                spare_way = base + w;
            end
        end
        r.status = ST_MISS;
        r.hit    = 1'b0;
        r.hop    = '0;
        if (op == OP_SET) begin
            if (hit_way >= 0) begin
                route_hop[hit_way] = hop;
                r.status = ST_UPDATED;
                r.hit    = 1'b1;
            end else if (spare_way >= 0) begin
                route_valid[spare_way] = 1'b1;
                route_dest[spare_way]  = dest;
                route_hop[spare_way]   = hop;
                r.status = ST_INSERTED;
            end
        end else if (hit_way >= 0) begin
            r.status = ST_FOUND;
            r.hit    = 1'b1;
            r.hop    = route_hop[hit_way];
        end
        return r;
    endfunction

    task automatic note_fault(string what);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_WAYS; i++)
                route_valid[i] = 1'b0;
            awaited_replies.delete();
        end else begin
            // results first: a word taken at this edge cannot answer yet
            if (i_valid) begin
                if (awaited_replies.size() == 0) begin
                    note_fault($sformatf("unexpected word: status %0d hit %0d hop %02h",
                                         i_status, i_hit, i_next_hop_out));
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_status !== want.status || i_hit !== want.hit ||
                        i_next_hop_out !== want.hop)
                        note_fault($sformatf(
                            "mismatch: want status %0d hit %0d hop %02h, got %0d %0d %02h",
                            want.status, want.hit, want.hop,
                            i_status, i_hit, i_next_hop_out));
                end
            end
            if (i_start && !i_busy)
                awaited_replies.push_back(route_word(t_op'(i_opcode), i_dest_node,
                                                     i_next_hop_in));
        end
        o_pending = awaited_replies.size();
    end

endmodule

// ----- tb/next_hop_routing_table_test.sv -----
`timescale 1ns / 1ps

module next_hop_routing_table_test;
    import nhrt_pkg::*;

    // Slowest run is ~1320 words at worst-case gaps plus the clearing pass;
    // the limit is several times over that.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1300;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic              busy;
    logic              i_opcode      = 1'b0;
    logic [DEST_W-1:0] i_dest_node   = '0;
    logic [HOP_W-1:0]  i_next_hop_in = '0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic              o_hit;
    logic [HOP_W-1:0]  o_next_hop_out;

    int fail_count;
    int pending;
    int cycles = 0;
    bit steady = 1'b0;   // when set, sender runs back-to-back

    always #6 i_clk = ~i_clk;

    next_hop_routing_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_dest_node    (i_dest_node),
        .i_next_hop_in  (i_next_hop_in),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_hit          (o_hit),
        .o_next_hop_out (o_next_hop_out)
    );

    // Predicts each result word from accepted input words and compares.
    next_hop_routing_table_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_dest_node    (i_dest_node),
        .i_next_hop_in  (i_next_hop_in),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_hit          (o_hit),
        .i_next_hop_out (o_next_hop_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Watchdog: a hung handshake or lost result ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("next_hop_routing_table_test: done, errors");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Drop start and idle; the word fields carry junk meanwhile,
    // which the block has to ignore.
    task automatic rest(int n);
        if (n > 0) begin
            start         <= 1'b0;
            i_opcode      <= 1'($urandom);
            i_dest_node   <= 8'($urandom);
            i_next_hop_in <= 8'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one word, hold it until busy is low at an edge, then maybe idle.
    // Always entered right after a rising edge.
    task automatic send_word(t_op op, logic [DEST_W-1:0] dest, logic [HOP_W-1:0] hop);
        start         <= 1'b1;
        i_opcode      <= op;
        i_dest_node   <= dest;
        i_next_hop_in <= hop;
        do @(posedge i_clk); while (busy);
        rest(pick_gap());
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain();
        rest(1);
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        logic [DEST_W-1:0] dest;
        logic [3:0]        hot_slot [4];
        t_op               op;

        hot_slot = '{4'd1, 4'd6, 4'd11, 4'd15};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // busy covers the clearing pass, so the first word just waits on it

        // Directed: slot 0 gets filled to capacity and overflowed, then hits,
        // updates and misses; extremes of key and next hop.
        send_word(OP_LOOKUP, 8'd5,   8'h00);   // lookup in an empty slot
        send_word(OP_SET,    8'd0,   8'h11);   // inserts into ways 0..3
        send_word(OP_SET,    8'd16,  8'h22);
        send_word(OP_SET,    8'd32,  8'h33);
        send_word(OP_SET,    8'd48,  8'h44);
        send_word(OP_SET,    8'd64,  8'h55);   // slot full, dropped
        send_word(OP_LOOKUP, 8'd16,  8'h00);
        send_word(OP_SET,    8'd32,  8'hFF);   // update of a matching way
        send_word(OP_LOOKUP, 8'd32,  8'h00);
        send_word(OP_LOOKUP, 8'd64,  8'h00);   // the dropped key stays absent
        send_word(OP_LOOKUP, 8'd80,  8'hFF);   // miss, next hop ignored
        send_word(OP_SET,    8'd255, 8'hFF);
        send_word(OP_LOOKUP, 8'd255, 8'h00);
        send_word(OP_SET,    8'd255, 8'h00);
        send_word(OP_LOOKUP, 8'd255, 8'hFF);
        send_word(OP_SET,    8'd0,   8'h00);
        send_word(OP_LOOKUP, 8'd0,   8'h00);   // hit carrying a zero hop
        send_word(OP_LOOKUP, 8'd48,  8'h00);
        drain();

        // Random: most keys land in four hot slots so chains fill, overflow
        // and get updated; the rest spread over the whole key space.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_WORDS / 2)
                drain();
            if ($urandom_range(0, 9) < 6)
                dest = {4'($urandom), hot_slot[$urandom_range(0, 3)]};
            else
                dest = 8'($urandom);
            op = ($urandom_range(0, 9) < 5) ? OP_LOOKUP : OP_SET;
            send_word(op, dest, 8'($urandom));
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("next_hop_routing_table_test: done, clean");
        end else begin
            $display("next_hop_routing_table_test: done, errors");
        end
        $finish;
    end

endmodule
